>>> hw/rtl/escape_time_fractal_pixel_unit_macros.svh
// Assertion macros shared by the escape-time fractal pixel unit.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_UNIT_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ETFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ETFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/etfp_pkg.sv
// Types, constants and helper functions of the escape-time fractal pixel unit.
package etfp_pkg;

  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 28;
  localparam int DIM_W    = 12;
  localparam int HEIGHT_W = 13;
  localparam int ITER_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int STEP_W   = COORD_W - 1;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int WIDE_W   = 2 * COORD_W + 1;
  localparam int MAP_W    = DIM_W + STEP_W + 2;
  localparam int ESC_POS  = 2 * FRAC_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd7;

  localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(1);
  localparam logic [ITER_W-1:0]   ITER_RST   = ITER_W'(255);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(4096);

  typedef struct packed {
    logic                      julia_mode;
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [STEP_W-1:0]         step_size;
    logic [ITER_W-1:0]         max_iterations;
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
    logic [HEIGHT_W-1:0]       image_height;
  } etfp_cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]          column;
    logic [DIM_W-1:0]          screen_row;
    logic signed [COORD_W-1:0] z_re;
    logic signed [COORD_W-1:0] z_im;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
  } etfp_job_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_UPD
  } core_state_e;

  // Clamps a wide signed value to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[WIDE_W-1]}}) begin
      r = v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/etfp_if.sv
// Pixel and result channel interfaces of the escape-time fractal pixel unit.
interface etfp_pix_if import etfp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] column;
  logic [DIM_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface etfp_res_if import etfp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   out_column;
  logic [DIM_W-1:0]   screen_row;
  logic [COUNT_W-1:0] iteration_count;

  modport source (output valid, output out_column, output screen_row,
                  output iteration_count, input ready);
  modport sink (input valid, input out_column, input screen_row,
                input iteration_count, output ready);
endinterface

>>> hw/rtl/escape_time_fractal_pixel_unit.sv
// Top level of the escape-time fractal pixel unit: configuration registers, front, queue, core.
//
//   Channel  Direction  Beat contents                               Handshake
//   pix_i    in         column, row                                 valid/ready
//   res_o    out        out_column, screen_row, iteration_count     valid/ready
//   cfg      in         cfg_idx_i, cfg_data_i                       cfg_we_i
//
// A pixel's job is first loaded from the queue; then each escape test takes a multiply step,
// which forms the three products of z in parallel, and an update step.
// The front maps the next pixel and queues it in FIFO_DEPTH entries while the core iterates.
// Reset clears all control state and loads the configuration registers with their defaults.
// A stalled result holds the core in its last update step; the queue keeps accepting pixels until full.
module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  etfp_pix_if.sink             pix_i,
  etfp_res_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  etfp_cfg_t cfg_q, cfg_d;
  etfp_job_t job_in, job_out;
  logic      push, pop, full, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_JULIA_MODE: cfg_d.julia_mode     = cfg_data_i[0];
        REG_X_ORIGIN:   cfg_d.x_origin       = $signed(cfg_data_i);
        REG_Y_ORIGIN:   cfg_d.y_origin       = $signed(cfg_data_i);
        REG_STEP_SIZE:  cfg_d.step_size      = cfg_data_i[STEP_W-1:0];
        REG_MAX_ITER:   cfg_d.max_iterations = cfg_data_i[ITER_W-1:0];
        REG_C_REAL:     cfg_d.c_real         = $signed(cfg_data_i);
        REG_C_IMAG:     cfg_d.c_imag         = $signed(cfg_data_i);
        REG_HEIGHT:     cfg_d.image_height   = cfg_data_i[HEIGHT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.julia_mode     <= 1'b0;
      cfg_q.x_origin       <= '0;
      cfg_q.y_origin       <= '0;
      cfg_q.step_size      <= STEP_RST;
      cfg_q.max_iterations <= ITER_RST;
      cfg_q.c_real         <= '0;
      cfg_q.c_imag         <= '0;
      cfg_q.image_height   <= HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  etfp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .push_o (push),
    .job_o  (job_in),
    .full_i (full)
  );

  etfp_fifo #(
    .WIDTH ($bits(etfp_job_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (job_out),
    .empty_o (empty)
  );

  etfp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

>>> hw/rtl/etfp_fifo.sv
// Small register queue that holds mapped pixel jobs between front and core.
`include "escape_time_fractal_pixel_unit_macros.svh"

module etfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ETFP_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "queue popped while empty")
  `ETFP_ASSERT_IMP(a_no_push_full, push_i, !full_o, "queue pushed while full")
  `ETFP_ASSERT_NXT(a_cnt_bound, push_i && !pop_i, !empty_o, "queue lost a pushed job")

endmodule

>>> hw/rtl/etfp_front.sv
// Front part: accepts pixels, maps them to plane points and builds iteration jobs.
module etfp_front import etfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  etfp_cfg_t          cfg_i,
  etfp_pix_if.sink           pix_i,
  output logic               push_o,
  output etfp_job_t          job_o,
  input  logic               full_i
);

  logic                       stg_valid_q;
  logic [DIM_W-1:0]           col_q, row_q;
  logic [DIM_W+STEP_W-1:0]    prod_x_q, prod_y_q;
  logic                       take;
  logic signed [MAP_W-1:0]    sum_x, sum_y;
  logic signed [COORD_W-1:0]  pt_x, pt_y;

  assign pix_i.ready = !stg_valid_q || !full_i;
  assign take        = pix_i.valid && pix_i.ready;
  assign push_o      = stg_valid_q && !full_i;

  assign sum_x = $signed({2'b00, prod_x_q}) + MAP_W'(cfg_i.x_origin);
  assign sum_y = $signed({2'b00, prod_y_q}) + MAP_W'(cfg_i.y_origin);
  assign pt_x  = sat_coord(WIDE_W'(sum_x));
  assign pt_y  = sat_coord(WIDE_W'(sum_y));

  always_comb begin
    job_o.column     = col_q;
    job_o.screen_row = DIM_W'(cfg_i.image_height - HEIGHT_W'(1) - HEIGHT_W'(row_q));
    if (cfg_i.julia_mode) begin
      job_o.z_re = pt_x;
      job_o.z_im = pt_y;
      job_o.c_re = cfg_i.c_real;
      job_o.c_im = cfg_i.c_imag;
    end else begin
      job_o.z_re = '0;
      job_o.z_im = '0;
      job_o.c_re = pt_x;
      job_o.c_im = pt_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (take) begin
      stg_valid_q <= 1'b1;
    end else if (push_o) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      col_q    <= pix_i.column;
      row_q    <= pix_i.row;
      prod_x_q <= (DIM_W + STEP_W)'(pix_i.column) * (DIM_W + STEP_W)'(cfg_i.step_size);
      prod_y_q <= (DIM_W + STEP_W)'(pix_i.row) * (DIM_W + STEP_W)'(cfg_i.step_size);
    end
  end

endmodule

>>> hw/rtl/etfp_core.sv
// Back part: iterates z = z^2 + c for one job and holds the finished result.
`include "escape_time_fractal_pixel_unit_macros.svh"

module etfp_core import etfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  etfp_cfg_t cfg_i,
  input  etfp_job_t job_i,
  input  logic      empty_i,
  output logic      pop_o,
  etfp_res_if.source res_o
);

  core_state_e state_q, state_d;

  logic signed [COORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic [DIM_W-1:0]          col_q, srow_q;
  logic [ITER_W-1:0]         cnt_q;
  logic signed [PROD_W-1:0]  a2_q, b2_q, ab_q;

  logic                      res_valid_q;
  logic [DIM_W-1:0]          res_col_q, res_srow_q;
  logic [COUNT_W-1:0]        res_cnt_q;

  logic [WIDE_W-1:0]         mag_sum;
  logic signed [WIDE_W-1:0]  re_full, im_full, re_sum, im_sum;
  logic                      escaped, fin, out_free, load_res, step_en, mul_en;

  assign mag_sum  = WIDE_W'(a2_q) + WIDE_W'(b2_q);
  assign escaped  = |mag_sum[WIDE_W-1:ESC_POS];
  assign re_full  = (WIDE_W'(a2_q) - WIDE_W'(b2_q)) >>> FRAC_W;
  assign im_full  = $signed({ab_q, 1'b0}) >>> FRAC_W;
  assign re_sum   = re_full + WIDE_W'(cr_q);
  assign im_sum   = im_full + WIDE_W'(ci_q);
  assign fin      = (cnt_q == cfg_i.max_iterations) || escaped;
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CORE_IDLE: begin
        if (!empty_i) begin
          state_d = CORE_MUL;
        end
      end
      CORE_MUL: begin
        state_d = CORE_UPD;
      end
      CORE_UPD: begin
        if (!fin) begin
          state_d = CORE_MUL;
        end else if (out_free) begin
          state_d = CORE_IDLE;
        end
      end
      default: begin
        state_d = CORE_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mul_en   = 1'b0;
    step_en  = 1'b0;
    load_res = 1'b0;
    case (state_q)
      CORE_IDLE: begin
        pop_o = !empty_i;
      end
      CORE_MUL: begin
        mul_en = 1'b1;
      end
      CORE_UPD: begin
        step_en  = !fin;
        load_res = fin && out_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CORE_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zr_q   <= job_i.z_re;
      zi_q   <= job_i.z_im;
      cr_q   <= job_i.c_re;
      ci_q   <= job_i.c_im;
      col_q  <= job_i.column;
      srow_q <= job_i.screen_row;
      cnt_q  <= '0;
    end else if (step_en) begin
      zr_q  <= sat_coord(re_sum);
      zi_q  <= sat_coord(im_sum);
      cnt_q <= cnt_q + ITER_W'(1);
    end
    if (mul_en) begin
      a2_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
      b2_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
      ab_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
    end
    if (load_res) begin
      res_col_q  <= col_q;
      res_srow_q <= srow_q;
      res_cnt_q  <= cnt_q[COUNT_W-1:0];
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.out_column      = res_col_q;
  assign res_o.screen_row      = res_srow_q;
  assign res_o.iteration_count = res_cnt_q;

  `ETFP_ASSERT_IMP(a_cnt_bound, state_q != CORE_IDLE, cnt_q <= cfg_i.max_iterations,
                   "iteration count passed the limit")
  `ETFP_ASSERT_IMP(a_res_from_upd, $rose(res_valid_q), $past(state_q == CORE_UPD),
                   "result appeared outside an update step")
  `ETFP_ASSERT_NXT(a_pop_starts, pop_o, state_q == CORE_MUL,
                   "popped job did not start iterating")

endmodule
